FILE: src/dhkv_pkg.sv
// ============================================================================
// dhkv_pkg
// Shared types and constants for the double-hash key/value table.
// ============================================================================
package dhkv_pkg;

    localparam int TABLE_SLOTS_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 32;
    localparam int HASH_BITS       = 64;
    localparam int KEY_BITS        = 64;
    localparam int MOD_BITS        = 11;
    localparam int LIMIT_BITS      = 7;
    localparam int MAX_LIMIT       = 64;
    localparam int PADDR_BITS      = 3;

    localparam logic [PADDR_BITS-1:0] ADDR_SLOTS = 3'd0;
    localparam logic [PADDR_BITS-1:0] ADDR_LIMIT = 3'd4;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_DELETED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    localparam logic [1:0] SLOT_VACANT   = 2'd0;
    localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
    localparam logic [1:0] SLOT_RELEASED = 2'd2;

endpackage

FILE: src/double_hash_key_value_table_unit.sv
// ============================================================================
// double_hash_key_value_table_unit
// Open-addressing key/value table with double hashing, APB configuration.
// ============================================================================
//  Channel   Handshake             Payload
//  in        in_valid / in_stall   req_type, key, hash_primary, hash_secondary, value
//  out       out_valid / out_stall status, found_value, old_value_valid, old_value,
//                                  entry_count
//  config    APB psel/penable      slots_in_use (0x0), probe_limit (0x4)
//
// The front end reduces both hashes one bit per cycle, then the probe engine
// examines each slot with a memory read and then a compare, and finishes.
// A clear sweeps the status memory. After reset the same sweep runs over every
// slot before the first probe starts.
// The two-entry queue lets the front end reduce the next item while a probe runs.
module double_hash_key_value_table_unit #(
    parameter int TABLE_SLOTS = dhkv_pkg::TABLE_SLOTS_DEF,
    parameter int VALUE_BITS  = dhkv_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dhkv_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           req_type,
    input  logic [dhkv_pkg::KEY_BITS-1:0]        key,
    input  logic [dhkv_pkg::HASH_BITS-1:0]       hash_primary,
    input  logic [dhkv_pkg::HASH_BITS-1:0]       hash_secondary,
    input  logic [31:0]                          value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2:0]                           status,
    output logic [31:0]                          found_value,
    output logic                                 old_value_valid,
    output logic [31:0]                          old_value,
    output logic [dhkv_pkg::MOD_BITS-1:0]        entry_count
);
    localparam int IDX_BITS = $clog2(TABLE_SLOTS);
    localparam int QW = 2 + dhkv_pkg::KEY_BITS + 32 + 2 * IDX_BITS;

    logic [dhkv_pkg::MOD_BITS-1:0]   slots_reg;
    logic [dhkv_pkg::LIMIT_BITS-1:0] limit_reg;
    logic [dhkv_pkg::MOD_BITS-1:0]   eff_mod;
    logic [dhkv_pkg::LIMIT_BITS-1:0] eff_lim;

    always_comb
    begin
        if (slots_reg < dhkv_pkg::MOD_BITS'(2))
            eff_mod = dhkv_pkg::MOD_BITS'(2);
        else if (32'(slots_reg) > 32'(TABLE_SLOTS))
            eff_mod = dhkv_pkg::MOD_BITS'(TABLE_SLOTS);
        else
            eff_mod = slots_reg;
        eff_lim = (limit_reg > dhkv_pkg::LIMIT_BITS'(dhkv_pkg::MAX_LIMIT))
                  ? dhkv_pkg::LIMIT_BITS'(dhkv_pkg::MAX_LIMIT) : limit_reg;
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= dhkv_pkg::MOD_BITS'(1024);
            limit_reg <= dhkv_pkg::LIMIT_BITS'(10);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == dhkv_pkg::ADDR_SLOTS)
                slots_reg <= pwdata[dhkv_pkg::MOD_BITS-1:0];
            else if (paddr == dhkv_pkg::ADDR_LIMIT)
                limit_reg <= pwdata[dhkv_pkg::LIMIT_BITS-1:0];
        end
    end

    always_comb
    begin
        if (paddr == dhkv_pkg::ADDR_SLOTS)
            prdata = 32'(slots_reg);
        else if (paddr == dhkv_pkg::ADDR_LIMIT)
            prdata = 32'(limit_reg);
        else
            prdata = '0;
    end

    logic                           fj_valid, fj_stall;
    logic [1:0]                     fj_req;
    logic [dhkv_pkg::KEY_BITS-1:0]  fj_key;
    logic [31:0]                    fj_value;
    logic [IDX_BITS-1:0]            fj_start, fj_step;
    logic                           bj_valid, bj_stall;
    logic [QW-1:0]                  bj_data;

    dhkv_front #(.IDX_BITS(IDX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .key(key), .hash_primary(hash_primary),
        .hash_secondary(hash_secondary), .value(value),
        .modulus(eff_mod),
        .job_valid(fj_valid), .job_stall(fj_stall),
        .job_req(fj_req), .job_key(fj_key), .job_value(fj_value),
        .job_start(fj_start), .job_step(fj_step)
    );

    dhkv_queue #(.WIDTH(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fj_valid), .wr_stall(fj_stall),
        .wr_data({fj_req, fj_key, fj_value, fj_start, fj_step}),
        .rd_valid(bj_valid), .rd_stall(bj_stall), .rd_data(bj_data)
    );

    dhkv_back #(
        .TABLE_SLOTS(TABLE_SLOTS), .VALUE_BITS(VALUE_BITS), .IDX_BITS(IDX_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(bj_valid), .job_stall(bj_stall),
        .job_req(bj_data[QW-1 -: 2]),
        .job_key(bj_data[QW-3 -: dhkv_pkg::KEY_BITS]),
        .job_value(bj_data[2*IDX_BITS+31 -: 32]),
        .job_start(bj_data[2*IDX_BITS-1 -: IDX_BITS]),
        .job_step(bj_data[IDX_BITS-1:0]),
        .modulus(eff_mod), .limit(eff_lim),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .found_value(found_value),
        .old_value_valid(old_value_valid), .old_value(old_value),
        .entry_count(entry_count)
    );
endmodule

FILE: src/dhkv_front.sv
// ============================================================================
// dhkv_front
// Accepts requests and, but for a clear, reduces both hashes modulo the slot
// count, one quotient bit per cycle, then hands a classified job to the queue.
// ============================================================================
module dhkv_front #(
    parameter int IDX_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [dhkv_pkg::KEY_BITS-1:0]     key,
    input  logic [dhkv_pkg::HASH_BITS-1:0]    hash_primary,
    input  logic [dhkv_pkg::HASH_BITS-1:0]    hash_secondary,
    input  logic [31:0]                       value,
    input  logic [dhkv_pkg::MOD_BITS-1:0]     modulus,
    output logic                              job_valid,
    input  logic                              job_stall,
    output logic [1:0]                        job_req,
    output logic [dhkv_pkg::KEY_BITS-1:0]     job_key,
    output logic [31:0]                       job_value,
    output logic [IDX_BITS-1:0]               job_start,
    output logic [IDX_BITS-1:0]               job_step
);
    typedef enum logic [1:0] {F_IDLE, F_REDUCE, F_DONE} fstate_t;

    localparam int CNT_BITS = $clog2(dhkv_pkg::HASH_BITS);

    fstate_t                            state_reg;
    logic [CNT_BITS-1:0]                cnt_reg;
    logic [dhkv_pkg::HASH_BITS-1:0]     h1_reg, h2_reg;
    logic [dhkv_pkg::MOD_BITS:0]        r1_reg, r2_reg;
    logic [1:0]                         req_reg;
    logic [dhkv_pkg::KEY_BITS-1:0]      key_reg;
    logic [31:0]                        val_reg;
    logic [dhkv_pkg::MOD_BITS:0]        s1, s2, mod_ext;

    assign mod_ext = {1'b0, modulus};
    // Restoring reduction: shift one hash bit in, subtract when it fits.
    assign s1 = {r1_reg[dhkv_pkg::MOD_BITS-1:0], h1_reg[dhkv_pkg::HASH_BITS-1]};
    assign s2 = {r2_reg[dhkv_pkg::MOD_BITS-1:0], h2_reg[dhkv_pkg::HASH_BITS-1]};

    assign in_stall  = (state_reg != F_IDLE);
    assign job_valid = (state_reg == F_DONE);
    assign job_req   = req_reg;
    assign job_key   = key_reg;
    assign job_value = val_reg;
    assign job_start = r1_reg[IDX_BITS-1:0];
    assign job_step  = r2_reg[IDX_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        h1_reg  <= hash_primary;
                        h2_reg  <= hash_secondary;
                        r1_reg  <= '0;
                        r2_reg  <= '0;
                        req_reg <= req_type;
                        key_reg <= key;
                        val_reg <= value;
                        cnt_reg <= '0;
                        state_reg <= (req_type == dhkv_pkg::REQ_CLEAR) ? F_DONE : F_REDUCE;
                    end
                end
                F_REDUCE:
                begin
                    r1_reg <= (s1 >= mod_ext) ? s1 - mod_ext : s1;
                    r2_reg <= (s2 >= mod_ext) ? s2 - mod_ext : s2;
                    h1_reg <= {h1_reg[dhkv_pkg::HASH_BITS-2:0], 1'b0};
                    h2_reg <= {h2_reg[dhkv_pkg::HASH_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(dhkv_pkg::HASH_BITS - 1))
                        state_reg <= F_DONE;
                end
                F_DONE:
                begin
                    if (!job_stall)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

FILE: src/dhkv_queue.sv
// ============================================================================
// dhkv_queue
// Two-entry queue between the hash front end and the probe engine.
// ============================================================================
module dhkv_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_stall,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_stall,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: src/dhkv_back.sv
// ============================================================================
// dhkv_back
// Probe engine: walks the probe sequence through the slot memories, applies
// the update and presents one result item. Clear sweeps the status memory.
// ============================================================================
module dhkv_back #(
    parameter int TABLE_SLOTS = 1024,
    parameter int VALUE_BITS  = 32,
    parameter int IDX_BITS    = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    output logic                           job_stall,
    input  logic [1:0]                     job_req,
    input  logic [dhkv_pkg::KEY_BITS-1:0]  job_key,
    input  logic [31:0]                    job_value,
    input  logic [IDX_BITS-1:0]            job_start,
    input  logic [IDX_BITS-1:0]            job_step,
    input  logic [dhkv_pkg::MOD_BITS-1:0]  modulus,
    input  logic [dhkv_pkg::LIMIT_BITS-1:0] limit,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [31:0]                    found_value,
    output logic                           old_value_valid,
    output logic [31:0]                    old_value,
    output logic [dhkv_pkg::MOD_BITS-1:0]  entry_count
);
    typedef enum logic [2:0] {B_INIT, B_IDLE, B_READ, B_EXAM, B_FINISH, B_CLEAR, B_OUT} bstate_t;

    bstate_t                           state_reg;
    logic [IDX_BITS-1:0]               idx_reg, sweep_reg;
    logic [dhkv_pkg::LIMIT_BITS-1:0]   left_reg;
    logic                              have_free_reg, have_match_reg;
    logic [IDX_BITS-1:0]               free_reg, match_reg;
    logic [1:0]                        req_reg;
    logic [dhkv_pkg::KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]             val_reg;
    logic [IDX_BITS-1:0]               step_reg;
    logic [dhkv_pkg::MOD_BITS-1:0]     count_reg;

    logic [1:0]                        stat_mem [TABLE_SLOTS];
    logic [dhkv_pkg::KEY_BITS-1:0]     key_mem  [TABLE_SLOTS];
    logic [VALUE_BITS-1:0]             val_mem  [TABLE_SLOTS];
    logic [1:0]                        rd_stat_reg;
    logic [dhkv_pkg::KEY_BITS-1:0]     rd_key_reg;
    logic [VALUE_BITS-1:0]             rd_val_reg;

    logic [2:0]                        status_reg;
    logic [31:0]                       found_reg, old_reg;
    logic                              oldok_reg;

    logic                              st_we, kv_we, v_we;
    logic [IDX_BITS-1:0]               st_addr, kv_addr, rd_addr;
    logic [1:0]                        st_wdata;
    logic [IDX_BITS:0]                 nxt_sum;
    logic [IDX_BITS-1:0]               nxt_idx;
    logic [31:0]                       rd_val32;
    logic                              last_slot;

    assign rd_val32 = 32'(rd_val_reg);
    assign nxt_sum  = {1'b0, idx_reg} + {1'b0, step_reg};
    assign nxt_idx  = (nxt_sum >= (IDX_BITS+1)'(modulus))
                      ? IDX_BITS'(nxt_sum - (IDX_BITS+1)'(modulus)) : nxt_sum[IDX_BITS-1:0];
    assign last_slot = (sweep_reg == IDX_BITS'(TABLE_SLOTS - 1));
    assign rd_addr  = idx_reg;

    // Write port control, decided in the finishing or sweeping cycle.
    always_comb
    begin
        st_we    = 1'b0;
        kv_we    = 1'b0;
        v_we     = 1'b0;
        st_addr  = sweep_reg;
        kv_addr  = free_reg;
        st_wdata = dhkv_pkg::SLOT_VACANT;
        if (state_reg == B_INIT || state_reg == B_CLEAR)
            st_we = 1'b1;
        else if (state_reg == B_FINISH)
        begin
            if (req_reg == dhkv_pkg::REQ_INSERT)
            begin
                if (have_match_reg)
                begin
                    v_we    = 1'b1;
                    kv_addr = match_reg;
                end
                else if (have_free_reg)
                begin
                    st_we    = 1'b1;
                    st_addr  = free_reg;
                    st_wdata = dhkv_pkg::SLOT_OCCUPIED;
                    kv_we    = 1'b1;
                    v_we     = 1'b1;
                end
            end
            else if (req_reg == dhkv_pkg::REQ_DELETE && have_match_reg)
            begin
                st_we    = 1'b1;
                st_addr  = match_reg;
                st_wdata = dhkv_pkg::SLOT_RELEASED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            stat_mem[st_addr] <= st_wdata;
        if (kv_we)
            key_mem[kv_addr] <= key_reg;
        if (v_we)
            val_mem[kv_addr] <= val_reg;
        rd_stat_reg <= stat_mem[rd_addr];
        rd_key_reg  <= key_mem[rd_addr];
        rd_val_reg  <= val_mem[rd_addr];
    end

    assign job_stall       = (state_reg != B_IDLE);
    assign out_valid       = (state_reg == B_OUT);
    assign status          = status_reg;
    assign found_value     = found_reg;
    assign old_value_valid = oldok_reg;
    assign old_value       = old_reg;
    assign entry_count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_INIT;
            sweep_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                B_INIT, B_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (last_slot)
                        state_reg <= (state_reg == B_INIT) ? B_IDLE : B_OUT;
                end
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        req_reg        <= job_req;
                        key_reg        <= job_key;
                        val_reg        <= VALUE_BITS'(job_value);
                        idx_reg        <= job_start;
                        step_reg       <= job_step;
                        left_reg       <= limit;
                        have_free_reg  <= 1'b0;
                        have_match_reg <= 1'b0;
                        found_reg      <= '0;
                        old_reg        <= '0;
                        oldok_reg      <= 1'b0;
                        sweep_reg      <= '0;
                        if (job_req == dhkv_pkg::REQ_CLEAR)
                        begin
                            status_reg <= dhkv_pkg::ST_CLEARED;
                            count_reg  <= '0;
                            state_reg  <= B_CLEAR;
                        end
                        else if (limit == '0)
                            state_reg <= B_FINISH;
                        else
                            state_reg <= B_READ;
                    end
                end
                B_READ:
                    state_reg <= B_EXAM;
                B_EXAM:
                begin
                    if (rd_stat_reg != dhkv_pkg::SLOT_OCCUPIED && !have_free_reg)
                    begin
                        have_free_reg <= 1'b1;
                        free_reg      <= idx_reg;
                    end
                    if (rd_stat_reg == dhkv_pkg::SLOT_VACANT)
                        state_reg <= B_FINISH;
                    else if (rd_stat_reg == dhkv_pkg::SLOT_OCCUPIED && rd_key_reg == key_reg)
                    begin
                        have_match_reg <= 1'b1;
                        match_reg      <= idx_reg;
                        state_reg      <= B_FINISH;
                    end
                    else if (left_reg == dhkv_pkg::LIMIT_BITS'(1))
                        state_reg <= B_FINISH;
                    else
                    begin
                        left_reg  <= left_reg - 1'b1;
                        idx_reg   <= nxt_idx;
                        state_reg <= B_READ;
                    end
                end
                B_FINISH:
                begin
                    state_reg <= B_OUT;
                    unique case (req_reg)
                        dhkv_pkg::REQ_INSERT:
                        begin
                            if (have_match_reg)
                            begin
                                status_reg <= dhkv_pkg::ST_UPDATED;
                                old_reg    <= rd_val32;
                                oldok_reg  <= 1'b1;
                            end
                            else if (have_free_reg)
                            begin
                                status_reg <= dhkv_pkg::ST_INSERTED;
                                count_reg  <= count_reg + 1'b1;
                            end
                            else
                                status_reg <= dhkv_pkg::ST_FULL;
                        end
                        dhkv_pkg::REQ_FIND:
                        begin
                            if (have_match_reg)
                            begin
                                status_reg <= dhkv_pkg::ST_FOUND;
                                found_reg  <= rd_val32;
                            end
                            else
                                status_reg <= dhkv_pkg::ST_MISSING;
                        end
                        default:
                        begin
                            if (have_match_reg)
                            begin
                                status_reg <= dhkv_pkg::ST_DELETED;
                                old_reg    <= rd_val32;
                                oldok_reg  <= 1'b1;
                                if (count_reg != '0)
                                    count_reg <= count_reg - 1'b1;
                            end
                            else
                                status_reg <= dhkv_pkg::ST_MISSING;
                        end
                    endcase
                end
                B_OUT:
                begin
                    if (!out_stall)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule
